// ===== hdl/spd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the status packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

   localparam int TICK_WIDTH_DEFAULT = 16;
   localparam int TIMEOUT_W          = 16;
   localparam int CSR_INDEX_W        = 2;
   localparam int CSR_DATA_W         = 16;

   localparam logic [7:0] HEADER_BYTE = 8'hFF;

   localparam logic [6:0]  ERROR_MASK_RESET    = 7'd127;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd100;
   localparam logic [7:0]  MAX_ID_RESET        = 8'd253;
   localparam logic [7:0]  MAX_LENGTH_RESET    = 8'd150;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ERROR_MASK    = 2'd0,
      REG_TIMEOUT_TICKS = 2'd1,
      REG_MAX_ID        = 2'd2,
      REG_MAX_LENGTH    = 2'd3
   } reg_index_type;

   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_BAD_HEADER  = 4'd1;
   localparam logic [3:0] ST_CHECKSUM    = 4'd2;
   localparam logic [3:0] ST_TIMEOUT     = 4'd3;
   localparam logic [3:0] ST_DEVICE_BASE = 4'd4;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic [7:0] packet_id;
      logic [3:0] status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  error_mask;
      logic [15:0] timeout_ticks;
      logic [7:0]  max_id;
      logic [7:0]  max_length;
   } cfg_type;

endpackage

// ===== hdl/status_packet_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_packet_deframer
// Servo bus status packet parser with per-byte parameter output and status.
// ----------------------------------------------------------------------------
// a result is computed combinationally from the accepted request and registered in the result queue, which drives rsp
// throughput: one request per cycle while the result queue has room; the packet state updates in one pass
// a two-entry result queue keeps req_ready high while one result waits
// reset (synchronous): parser idle and not armed, queue empty,
// registers back to error_mask 127, timeout_ticks 100, max_id 253, max_length 150
module status_packet_deframer
   import spd_pkg::*;
#(
   parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    req_take;
   logic    res_valid;
   rsp_type res_data;
   logic    has_room;

   assign csr_ready = 1'b1;
   assign req_ready = has_room;
   assign req_take  = req_valid && has_room;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_ERROR_MASK:    cfg_in.error_mask    = csr_data[6:0];
            REG_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_data[15:0];
            REG_MAX_ID:        cfg_in.max_id        = csr_data[7:0];
            REG_MAX_LENGTH:    cfg_in.max_length    = csr_data[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.error_mask    <= ERROR_MASK_RESET;
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RESET;
         cfg_ff.max_id        <= MAX_ID_RESET;
         cfg_ff.max_length    <= MAX_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   spd_parser #(
      .TICK_WIDTH(TICK_WIDTH)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_take (req_take),
      .req_data (req_data),
      .res_valid(res_valid),
      .res_data (res_data)
   );

   spd_out_queue u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (res_valid),
      .push_data(res_data),
      .has_room (has_room),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

// ===== hdl/spd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_parser
// Packet state machine: one request per cycle, at most one result per request.
// ----------------------------------------------------------------------------
module spd_parser
   import spd_pkg::*;
#(
   parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_take,
   input  req_type req_data,
   output logic    res_valid,
   output rsp_type res_data
);

   localparam int CMP_W = (TICK_WIDTH > TIMEOUT_W) ? TICK_WIDTH : TIMEOUT_W;

   typedef enum logic [2:0] {
      PH_IDLE, PH_HDR0, PH_HDR1, PH_ID, PH_LEN, PH_ERR, PH_PARAM, PH_CHK
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [7:0]            device_id_ff, device_id_in;
   logic [7:0]            length_left_ff, length_left_in;
   logic [7:0]            param_count_ff, param_count_in;
   logic [7:0]            running_sum_ff, running_sum_in;
   logic [6:0]            device_error_ff, device_error_in;
   logic [TICK_WIDTH-1:0] tick_count_ff, tick_count_in;

   logic [7:0]            b;
   logic [6:0]            hits;
   logic [3:0]            err_status;
   logic                  err_hit;

   assign b    = req_data.rx_byte;
   assign hits = device_error_ff & cfg.error_mask;

   // lowest masked device error bit wins
   always_comb begin
      err_hit    = 1'b0;
      err_status = ST_OK;
      for (int i = 6; i >= 0; i--) begin
         if (hits[i]) begin
            err_hit    = 1'b1;
            err_status = ST_DEVICE_BASE + 4'(i);
         end
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      device_id_in    = device_id_ff;
      length_left_in  = length_left_ff;
      param_count_in  = param_count_ff;
      running_sum_in  = running_sum_ff;
      device_error_in = device_error_ff;
      tick_count_in   = tick_count_ff;
      res_valid       = 1'b0;
      res_data.kind       = 1'b1;
      res_data.data_byte  = 8'd0;
      res_data.byte_index = 8'd0;
      res_data.packet_id  = device_id_ff;
      res_data.status     = ST_OK;
      res_data.last       = 1'b1;

      if (req_take) begin
         if (req_data.operation == OP_START) begin
            phase_in        = PH_HDR0;
            device_id_in    = 8'd0;
            length_left_in  = 8'd0;
            param_count_in  = 8'd0;
            running_sum_in  = 8'd0;
            device_error_in = 7'd0;
            tick_count_in   = '0;
         end else if (phase_ff != PH_IDLE) begin
            if (req_data.operation == OP_TICK) begin
               if (tick_count_ff != {TICK_WIDTH{1'b1}}) begin
                  tick_count_in = tick_count_ff + 1'b1;
               end
               if (CMP_W'(tick_count_in) > CMP_W'(cfg.timeout_ticks)) begin
                  res_valid       = 1'b1;
                  res_data.status = ST_TIMEOUT;
                  phase_in        = PH_IDLE;
               end
            end else if (req_data.operation == OP_BYTE) begin
               case (phase_ff)
                  PH_HDR0, PH_HDR1: begin
                     if (b != HEADER_BYTE) begin
                        res_valid       = 1'b1;
                        res_data.status = ST_BAD_HEADER;
                        phase_in        = PH_IDLE;
                     end else begin
                        phase_in = (phase_ff == PH_HDR0) ? PH_HDR1 : PH_ID;
                     end
                  end
                  PH_ID: begin
                     if (b > cfg.max_id) begin
                        res_valid       = 1'b1;
                        res_data.status = ST_BAD_HEADER;
                        phase_in        = PH_IDLE;
                     end else begin
                        device_id_in   = b;
                        running_sum_in = b;
                        phase_in       = PH_LEN;
                     end
                  end
                  PH_LEN: begin
                     if (b < 8'd2 || b > cfg.max_length) begin
                        res_valid       = 1'b1;
                        res_data.status = ST_BAD_HEADER;
                        phase_in        = PH_IDLE;
                     end else begin
                        running_sum_in = running_sum_ff + b;
                        length_left_in = b - 8'd2;
                        phase_in       = PH_ERR;
                     end
                  end
                  PH_ERR: begin
                     // bit 7 goes into the checksum only
                     device_error_in = b[6:0];
                     running_sum_in  = running_sum_ff + b;
                     param_count_in  = 8'd0;
                     phase_in        = (length_left_ff != 8'd0) ? PH_PARAM : PH_CHK;
                  end
                  PH_PARAM: begin
                     res_valid           = 1'b1;
                     res_data.kind       = 1'b0;
                     res_data.data_byte  = b;
                     res_data.byte_index = param_count_ff;
                     res_data.last       = 1'b0;
                     running_sum_in      = running_sum_ff + b;
                     param_count_in      = param_count_ff + 8'd1;
                     length_left_in      = length_left_ff - 8'd1;
                     if (length_left_in == 8'd0) begin
                        phase_in = PH_CHK;
                     end
                  end
                  PH_CHK: begin
                     res_valid = 1'b1;
                     phase_in  = PH_IDLE;
                     if (err_hit) begin
                        res_data.status = err_status;
                     end else if (~running_sum_ff != b) begin
                        res_data.status = ST_CHECKSUM;
                     end else begin
                        res_data.status = ST_OK;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         device_id_ff    <= 8'd0;
         length_left_ff  <= 8'd0;
         param_count_ff  <= 8'd0;
         running_sum_ff  <= 8'd0;
         device_error_ff <= 7'd0;
         tick_count_ff   <= '0;
      end else begin
         phase_ff        <= phase_in;
         device_id_ff    <= device_id_in;
         length_left_ff  <= length_left_in;
         param_count_ff  <= param_count_in;
         running_sum_ff  <= running_sum_in;
         device_error_ff <= device_error_in;
         tick_count_ff   <= tick_count_in;
      end
   end

endmodule

// ===== hdl/spd_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_out_queue
// Two-entry result queue that decouples the parser from a stalled consumer.
// ----------------------------------------------------------------------------
module spd_out_queue
   import spd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    has_room,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = (count_ff != 2'd0) && rsp_ready;
   assign has_room  = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== dv/tb_status_packet_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_status_packet_deframer
// Self-checking bench for the status packet deframer: directed packets cover
// the header, checksum, device error, restart and timeout corners, then
// random packets run under several register settings. A shadow parser
// predicts every response and a monitor compares them in order.
// ----------------------------------------------------------------------------
module tb_status_packet_deframer;
   import spd_pkg::*;

   localparam int CLK_HALF     = 2;
   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 8;
   localparam int LIMIT_CYCLES = 400000;
   localparam int IDLE_PCT     = 23;

   typedef enum logic [2:0] {
      PARSE_IDLE,
      PARSE_HDR0,
      PARSE_HDR1,
      PARSE_ID,
      PARSE_LEN,
      PARSE_ERR,
      PARSE_PARAM,
      PARSE_CHK
   } parse_phase_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // shadow parser state
   cfg_type         shadow_cfg;
   parse_phase_type parse_phase;
   logic [7:0]      cur_id;
   logic [7:0]      bytes_left;
   logic [7:0]      param_idx;
   logic [7:0]      csum;
   logic [6:0]      dev_err;
   logic [15:0]     tick_cnt;

   rsp_type      expected_rsp [$];
   rsp_type      want_rsp;
   int unsigned  error_count = 0;
   int unsigned  live_items = 0;
   int unsigned  cycle_count = 0;
   bit           gaps_on = 1'b1;

   status_packet_deframer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= gaps_on ? ($urandom_range(99, 0) >= IDLE_PCT) : 1'b1;
   end

   // ------------------------------------------------------------------------
   // shadow parser
   // ------------------------------------------------------------------------
   task automatic clear_packet();
      cur_id     = '0;
      bytes_left = '0;
      param_idx  = '0;
      csum       = '0;
      dev_err    = '0;
      tick_cnt   = '0;
   endtask

   task automatic push_status(input logic [3:0] st);
      expected_rsp.push_back('{kind: 1'b1, data_byte: 8'd0, byte_index: 8'd0,
                               packet_id: cur_id, status: st, last: 1'b1});
      parse_phase = PARSE_IDLE;
   endtask

   task automatic parse_byte(input logic [7:0] b);
      logic [6:0] hits;
      logic [3:0] st;
      case (parse_phase)
         PARSE_HDR0, PARSE_HDR1: begin
            if (b != HEADER_BYTE) push_status(ST_BAD_HEADER);
            else parse_phase = (parse_phase == PARSE_HDR0) ? PARSE_HDR1 : PARSE_ID;
         end
         PARSE_ID: begin
            if (b > shadow_cfg.max_id) begin
               push_status(ST_BAD_HEADER);
            end else begin
               cur_id      = b;
               csum        = b;
               parse_phase = PARSE_LEN;
            end
         end
         PARSE_LEN: begin
            if (b < 8'd2 || b > shadow_cfg.max_length) begin
               push_status(ST_BAD_HEADER);
            end else begin
               csum        = csum + b;
               bytes_left  = b - 8'd2;
               parse_phase = PARSE_ERR;
            end
         end
         PARSE_ERR: begin
            // bit 7 only feeds the checksum
            dev_err     = b[6:0];
            csum        = csum + b;
            param_idx   = '0;
            parse_phase = (bytes_left != 0) ? PARSE_PARAM : PARSE_CHK;
         end
         PARSE_PARAM: begin
            expected_rsp.push_back('{kind: 1'b0, data_byte: b, byte_index: param_idx,
                                     packet_id: cur_id, status: ST_OK, last: 1'b0});
            csum       = csum + b;
            param_idx  = param_idx + 8'd1;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 0) parse_phase = PARSE_CHK;
         end
         PARSE_CHK: begin
            hits = dev_err & shadow_cfg.error_mask;
            st   = ST_OK;
            // walk down so the lowest set bit wins
            for (int i = 6; i >= 0; i--) begin
               if (hits[i]) st = ST_DEVICE_BASE + 4'(i);
            end
            if (hits == 0 && ~csum != b) st = ST_CHECKSUM;
            push_status(st);
         end
         default: ;
      endcase
   endtask

   task automatic parse_request(input req_type r);
      case (r.operation)
         OP_START: begin
            clear_packet();
            parse_phase = PARSE_HDR0;
         end
         OP_BYTE: begin
            if (parse_phase != PARSE_IDLE) parse_byte(r.rx_byte);
         end
         OP_TICK: begin
            if (parse_phase != PARSE_IDLE) begin
               if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
               if (tick_cnt > shadow_cfg.timeout_ticks) push_status(ST_TIMEOUT);
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // responses are checked before the request of the same edge is predicted
   always @(posedge clock) begin
      if (reset) begin
         shadow_cfg  = '{error_mask: ERROR_MASK_RESET, timeout_ticks: TIMEOUT_TICKS_RESET,
                         max_id: MAX_ID_RESET, max_length: MAX_LENGTH_RESET};
         parse_phase = PARSE_IDLE;
         clear_packet();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response with none expected: %h", rsp_data);
               error_count++;
            end else begin
               want_rsp = expected_rsp.pop_front();
               check_field("kind", want_rsp.kind, rsp_data.kind);
               check_field("data_byte", want_rsp.data_byte, rsp_data.data_byte);
               check_field("byte_index", want_rsp.byte_index, rsp_data.byte_index);
               check_field("packet_id", want_rsp.packet_id, rsp_data.packet_id);
               check_field("status", want_rsp.status, rsp_data.status);
               check_field("last", want_rsp.last, rsp_data.last);
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.operation == OP_START ||
                (parse_phase != PARSE_IDLE && req_data.operation != OP_NONE))
               live_items++;
            parse_request(req_data);
         end
      end
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic send_req(input logic [1:0] op, input logic [7:0] b);
      @(negedge clock);
      while (gaps_on && $urandom_range(99, 0) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{operation: op, rx_byte: b};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_ERROR_MASK:    shadow_cfg.error_mask    = val[6:0];
         REG_TIMEOUT_TICKS: shadow_cfg.timeout_ticks = val;
         REG_MAX_ID:        shadow_cfg.max_id        = val[7:0];
         REG_MAX_LENGTH:    shadow_cfg.max_length    = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [6:0] mask, input logic [15:0] timeout,
                            input logic [7:0] id_max, input logic [7:0] len_max);
      wait_drained();
      write_csr(REG_ERROR_MASK, 16'(mask));
      write_csr(REG_TIMEOUT_TICKS, timeout);
      write_csr(REG_MAX_ID, 16'(id_max));
      write_csr(REG_MAX_LENGTH, 16'(len_max));
   endtask

   // one packet, mostly well formed, sometimes broken on purpose
   task automatic run_random_packet(input bit long_pkt);
      logic [7:0]  pkt [$];
      logic [7:0]  len;
      logic [7:0]  sum;
      int unsigned mode;
      int unsigned cap;
      int unsigned cut;
      mode = $urandom_range(99, 0);
      sum  = '0;
      cap  = (shadow_cfg.max_length < 10) ? shadow_cfg.max_length : 10;
      len  = long_pkt ? shadow_cfg.max_length : 8'($urandom_range(cap, 2));
      pkt.push_back(HEADER_BYTE);
      pkt.push_back(HEADER_BYTE);
      pkt.push_back(8'($urandom_range(shadow_cfg.max_id, 0)));
      pkt.push_back(len);
      pkt.push_back(($urandom_range(99, 0) < 60) ? {1'($urandom), 7'd0} : 8'($urandom));
      repeat (len - 2) pkt.push_back(8'($urandom));
      for (int i = 2; i < pkt.size(); i++) sum = sum + pkt[i];
      pkt.push_back(($urandom_range(99, 0) < 15) ? (~sum ^ (8'd1 << $urandom_range(7, 0)))
                                                 : ~sum);
      cut = pkt.size();
      if (mode >= 80 && mode < 84) begin
         pkt[$urandom_range(1, 0)] = 8'($urandom_range(254, 0));
      end else if (mode >= 84 && mode < 87 && shadow_cfg.max_id != 8'hFF) begin
         pkt[2] = 8'($urandom_range(255, shadow_cfg.max_id + 1));
      end else if (mode >= 87 && mode < 90) begin
         if ($urandom_range(1, 0) == 0 || shadow_cfg.max_length == 8'hFF)
            pkt[3] = 8'($urandom_range(1, 0));
         else
            pkt[3] = 8'($urandom_range(255, shadow_cfg.max_length + 1));
      end else if (mode >= 90) begin
         // cut short; the next start drops it or the tick burst times it out
         cut = $urandom_range(pkt.size() - 1, 0);
      end
      send_req(OP_START, 8'($urandom));
      for (int i = 0; i < cut; i++) begin
         if ($urandom_range(99, 0) < 5) send_req(OP_TICK, 8'($urandom));
         if ($urandom_range(99, 0) < 2) send_req(OP_NONE, 8'($urandom));
         send_req(OP_BYTE, pkt[i]);
      end
      if (mode >= 95 && shadow_cfg.timeout_ticks <= 300)
         repeat (shadow_cfg.timeout_ticks + 1) send_req(OP_TICK, 8'($urandom));
   endtask

   task automatic run_packets(input int unsigned target, input bit with_long,
                              input bit with_pause);
      int unsigned base;
      bit          paused;
      base   = live_items;
      paused = 1'b0;
      if (with_long) run_random_packet(1'b1);
      while (live_items - base < target) begin
         // noise between packets, mostly ignored by an idle parser
         if ($urandom_range(99, 0) < 5)
            send_req(2'($urandom_range(3, 1)), 8'($urandom));
         run_random_packet(1'b0);
         if (with_pause && !paused && live_items - base >= target / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_idle_ignored();
      send_req(OP_BYTE, HEADER_BYTE);
      send_req(OP_TICK, 8'h00);
      send_req(OP_NONE, 8'hA5);
   endtask

   task automatic test_good_packet();
      send_req(OP_START, 8'h5A);
      send_req(OP_BYTE, HEADER_BYTE);
      send_req(OP_BYTE, HEADER_BYTE);
      send_req(OP_BYTE, 8'd253);
      send_req(OP_BYTE, 8'd4);
      send_req(OP_BYTE, 8'h80);
      send_req(OP_BYTE, 8'h00);
      send_req(OP_NONE, 8'hFF);
      send_req(OP_BYTE, 8'hFF);
      send_req(OP_BYTE, 8'h7F);
   endtask

   task automatic test_restart_and_short_length();
      send_req(OP_START, 8'h00);
      send_req(OP_BYTE, HEADER_BYTE);
      send_req(OP_START, 8'hFF);
      send_req(OP_BYTE, HEADER_BYTE);
      send_req(OP_BYTE, HEADER_BYTE);
      send_req(OP_BYTE, 8'd0);
      send_req(OP_BYTE, 8'd1);
   endtask

   task automatic test_error_beats_checksum();
      send_req(OP_START, 8'h00);
      send_req(OP_BYTE, HEADER_BYTE);
      send_req(OP_BYTE, HEADER_BYTE);
      send_req(OP_BYTE, 8'd0);
      send_req(OP_BYTE, 8'd2);
      send_req(OP_BYTE, 8'h41);
      send_req(OP_BYTE, 8'h00);
   endtask

   task automatic test_zero_timeout();
      wait_drained();
      write_csr(REG_TIMEOUT_TICKS, 16'd0);
      send_req(OP_START, 8'h33);
      send_req(OP_TICK, 8'hCC);
   endtask

   task automatic test_random_reset_config();
      configure(ERROR_MASK_RESET, TIMEOUT_TICKS_RESET, MAX_ID_RESET, MAX_LENGTH_RESET);
      run_packets(200, 1'b0, 1'b0);
   endtask

   task automatic test_random_wide_open();
      configure(7'd0, 16'hFFFF, 8'hFF, 8'hFF);
      gaps_on = 1'b0;
      run_packets(300, 1'b1, 1'b0);
      gaps_on = 1'b1;
   endtask

   task automatic test_random_tight();
      configure(7'h7F, 16'd1, 8'd0, 8'd2);
      run_packets(120, 1'b0, 1'b0);
   endtask

   task automatic test_random_mixed();
      repeat (3) begin
         configure(7'($urandom_range(127, 0)),
                   ($urandom_range(3, 0) == 0) ? 16'hFFFF : 16'($urandom_range(300, 1)),
                   8'($urandom_range(255, 0)), 8'($urandom_range(255, 2)));
         run_packets(110, 1'b0, 1'b1);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_idle_ignored();
      test_good_packet();
      test_restart_and_short_length();
      test_error_beats_checksum();
      test_zero_timeout();
      test_random_reset_config();
      test_random_wide_open();
      test_random_tight();
      test_random_mixed();
      wait_drained();
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
